>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on i_clk; ASSERT_CLK adds a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked while reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property that must hold at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> src/pngck_pkg.sv
// ----------------------------------------------------------------------------
// pngck_pkg
// Types and constants of the PNG chunk structure checker.
// ----------------------------------------------------------------------------
package pngck_pkg;

    localparam int OFFSET_BITS = 32;

    localparam logic [31:0] TYPE_IHDR     = 32'h4948_4452;
    localparam logic [31:0] TYPE_IDAT     = 32'h4944_4154;
    localparam logic [31:0] TYPE_IEND     = 32'h4945_4E44;
    localparam logic [31:0] IHDR_DATA_LEN = 32'd13;

    // Signature bytes in file order.
    localparam logic [7:0] SIG_BYTES [8] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    localparam logic [2:0] VERDICT_GOOD     = 3'd0;
    localparam logic [2:0] VERDICT_BAD_SIG  = 3'd1;
    localparam logic [2:0] VERDICT_BAD_IHDR = 3'd2;
    localparam logic [2:0] VERDICT_BAD_IEND = 3'd3;
    localparam logic [2:0] VERDICT_NO_IDAT  = 3'd4;

    localparam logic KIND_IDAT    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam int RES_BITS = 32 + 32 + 32 + 3;
    localparam int M_TDATA_W = ((RES_BITS + 7) / 8) * 8;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_SIG,
        PH_HLEN,
        PH_HTYPE,
        PH_HSKIP,
        PH_CLEN,
        PH_CTYPE,
        PH_IDATA,
        PH_ICRC,
        PH_SKIP,
        PH_TAIL
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [31:0] offset;
        logic [31:0] length;
        logic [31:0] crc;
        logic [2:0]  verdict;
        logic        last;
    } t_result;

endpackage

>>> src/png_chunk_structure_checker_core.sv
// A result is written into the result queue by the byte transfer that causes it.
// Throughput: one byte per cycle while results are taken; the four-entry result queue
// holds off new bytes when fewer than two entries are free. A final byte that closes an
// IDAT CRC yields two results, which are written into the queue together.
// Reset is synchronous and active low; it clears the parser state and the queue.
// ----------------------------------------------------------------------------
// png_chunk_structure_checker_core
// Walks a PNG byte stream, reports IDAT chunks and gives a verdict per file.
// ----------------------------------------------------------------------------
module png_chunk_structure_checker_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Slave side. tdata: data_byte [7:0].
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,
    // tlast: last_byte.
    input  logic                           s_axis_tlast,
    // Master side. tdata: chunk_offset [31:0], chunk_length [63:32],
    // chunk_crc [95:64], verdict [98:96], zero fill above.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [pngck_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: report_kind.
    output logic                           m_axis_tuser,
    // tlast: final_of_run.
    output logic                           m_axis_tlast
);
    import pngck_pkg::*;

    // Parser state. The byte offset saturates at all ones.
    t_phase                 r_phase, n_phase;
    logic [2:0]             r_fcnt, n_fcnt;
    logic [31:0]            r_word, n_word;
    logic [31:0]            r_len, n_len;
    logic [32:0]            r_skip, n_skip;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [OFFSET_BITS-1:0] r_cstart, n_cstart;
    logic                   r_idat, n_idat;
    logic [2:0]             r_fail, n_fail;

    // Result queue.
    t_result                r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]       r_wptr, r_rptr;
    logic [CNT_W-1:0]       r_cnt;

    logic                   w_acc;
    logic                   w_last_acc;
    logic                   w_hold_fail;
    logic                   w_rd;
    logic [31:0]            w_word;
    logic                   w_word_done;
    logic [32:0]            w_skip_dec;
    logic                   w_emit_report;
    logic [2:0]             w_verdict;
    logic [1:0]             w_wr_cnt;
    t_result                w_res_report;
    t_result                w_res_verdict;
    t_result                w_head;

    // Byte transfers are taken while two queue entries are free, so a final byte
    // can always push both its IDAT report and its verdict.
    assign s_axis_tready = (r_cnt <= CNT_W'(FIFO_DEPTH - 2));
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_last_acc    = w_acc && s_axis_tlast;
    assign w_hold_fail   = (r_fail != VERDICT_GOOD) && !w_last_acc;

    // Shared word assembly for the four-byte big-endian fields.
    assign w_word      = {r_word[23:0], s_axis_tdata};
    assign w_word_done = (r_fcnt >= 3'd3);
    assign w_skip_dec  = (r_skip != 33'd0) ? (r_skip - 33'd1) : r_skip;

    // Next state of the parser for an accepted byte.
    always_comb begin
        t_phase      h_phase;
        logic [2:0]  h_fcnt;
        logic [31:0] h_word;
        logic [31:0] h_len;
        logic [32:0] h_skip;
        logic [OFFSET_BITS-1:0] h_cstart;
        logic        h_idat;
        logic [2:0]  h_fail;

        h_phase  = r_phase;
        h_fcnt   = r_fcnt;
        h_word   = r_word;
        h_len    = r_len;
        h_skip   = r_skip;
        h_cstart = r_cstart;
        h_idat   = r_idat;
        h_fail   = r_fail;

        // Once a failure is recorded, bytes only advance the offset.
        if (r_fail == VERDICT_GOOD) begin
            case (r_phase)
                PH_SIG: begin
                    if (SIG_BYTES[r_fcnt] != s_axis_tdata) begin
                        h_fail = VERDICT_BAD_SIG;
                    end else if (r_fcnt == 3'd7) begin
                        h_fcnt  = 3'd0;
                        h_phase = PH_HLEN;
                    end else begin
                        h_fcnt = r_fcnt + 3'd1;
                    end
                end
                PH_HLEN, PH_HTYPE, PH_CLEN, PH_CTYPE, PH_ICRC: begin
                    h_word = w_word;
                    h_fcnt = w_word_done ? 3'd0 : (r_fcnt + 3'd1);
                    if (r_phase == PH_CLEN && r_fcnt == 3'd0) begin
                        h_cstart = r_off;
                    end
                    if (w_word_done) begin
                        case (r_phase)
                            PH_HLEN: begin
                                if (w_word != IHDR_DATA_LEN) begin
                                    h_fail = VERDICT_BAD_IHDR;
                                end else begin
                                    h_phase = PH_HTYPE;
                                end
                            end
                            PH_HTYPE: begin
                                if (w_word != TYPE_IHDR) begin
                                    h_fail = VERDICT_BAD_IHDR;
                                end else begin
                                    h_phase = PH_HSKIP;
                                    h_skip  = {1'b0, IHDR_DATA_LEN} + 33'd4;
                                end
                            end
                            PH_CLEN: begin
                                h_len   = w_word;
                                h_phase = PH_CTYPE;
                            end
                            PH_CTYPE: begin
                                if (w_word == TYPE_IDAT) begin
                                    h_idat  = 1'b1;
                                    h_skip  = {1'b0, r_len};
                                    h_phase = (r_len == 32'd0) ? PH_ICRC : PH_IDATA;
                                end else if (w_word == TYPE_IEND) begin
                                    if (r_len != 32'd0) begin
                                        h_fail = VERDICT_BAD_IEND;
                                    end else begin
                                        h_skip  = 33'd4;
                                        h_phase = PH_TAIL;
                                    end
                                end else begin
                                    h_skip  = {1'b0, r_len} + 33'd4;
                                    h_phase = PH_SKIP;
                                end
                            end
                            default: begin
                                h_phase = PH_CLEN;
                            end
                        endcase
                    end
                end
                PH_HSKIP, PH_SKIP: begin
                    h_skip = w_skip_dec;
                    if (w_skip_dec == 33'd0) begin
                        h_phase = PH_CLEN;
                    end
                end
                PH_IDATA: begin
                    h_skip = w_skip_dec;
                    if (w_skip_dec == 33'd0) begin
                        h_phase = PH_ICRC;
                    end
                end
                PH_TAIL: begin
                    // Any byte past the four CRC bytes of IEND is an error.
                    if (r_skip == 33'd0) begin
                        h_fail = VERDICT_BAD_IEND;
                    end else begin
                        h_skip = w_skip_dec;
                    end
                end
                default: begin
                    h_fail = VERDICT_BAD_IEND;
                end
            endcase
        end

        // Verdict from the state after this byte; a recorded failure wins.
        if (h_fail != VERDICT_GOOD) begin
            w_verdict = h_fail;
        end else if (h_phase == PH_SIG) begin
            w_verdict = VERDICT_BAD_SIG;
        end else if (h_phase == PH_HLEN || h_phase == PH_HTYPE) begin
            w_verdict = VERDICT_BAD_IHDR;
        end else if (h_phase == PH_TAIL && h_skip == 33'd0) begin
            w_verdict = h_idat ? VERDICT_GOOD : VERDICT_NO_IDAT;
        end else begin
            w_verdict = VERDICT_BAD_IEND;
        end

        n_off = (r_off != {OFFSET_BITS{1'b1}}) ? (r_off + OFFSET_BITS'(1)) : r_off;

        // The final byte returns the parser to its reset state for the next file.
        if (s_axis_tlast) begin
            n_phase  = PH_SIG;
            n_fcnt   = 3'd0;
            n_word   = 32'd0;
            n_len    = 32'd0;
            n_skip   = 33'd0;
            n_off    = '0;
            n_cstart = '0;
            n_idat   = 1'b0;
            n_fail   = VERDICT_GOOD;
        end else begin
            n_phase  = h_phase;
            n_fcnt   = h_fcnt;
            n_word   = h_word;
            n_len    = h_len;
            n_skip   = h_skip;
            n_cstart = h_cstart;
            n_idat   = h_idat;
            n_fail   = h_fail;
        end
    end

    // Results caused by the byte on the slave side.
    always_comb begin
        w_emit_report = (r_fail == VERDICT_GOOD) && (r_phase == PH_ICRC) && w_word_done;

        w_res_report.kind    = KIND_IDAT;
        w_res_report.offset  = 32'(r_cstart);
        w_res_report.length  = r_len;
        w_res_report.crc     = w_word;
        w_res_report.verdict = VERDICT_GOOD;
        w_res_report.last    = !s_axis_tlast;

        w_res_verdict.kind    = KIND_VERDICT;
        w_res_verdict.offset  = 32'd0;
        w_res_verdict.length  = 32'd0;
        w_res_verdict.crc     = 32'd0;
        w_res_verdict.verdict = w_verdict;
        w_res_verdict.last    = 1'b1;

        if (w_acc) begin
            w_wr_cnt = {1'b0, w_emit_report} + {1'b0, s_axis_tlast};
        end else begin
            w_wr_cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SIG;
            r_fcnt   <= 3'd0;
            r_word   <= 32'd0;
            r_len    <= 32'd0;
            r_skip   <= 33'd0;
            r_off    <= '0;
            r_cstart <= '0;
            r_idat   <= 1'b0;
            r_fail   <= VERDICT_GOOD;
        end else if (w_acc) begin
            r_phase  <= n_phase;
            r_fcnt   <= n_fcnt;
            r_word   <= n_word;
            r_len    <= n_len;
            r_skip   <= n_skip;
            r_off    <= n_off;
            r_cstart <= n_cstart;
            r_idat   <= n_idat;
            r_fail   <= n_fail;
        end
    end

    // Result queue: up to two writes and one read per cycle.
    assign w_head = r_mem[r_rptr];
    assign w_rd   = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_wr_cnt != 2'd0) begin
            r_mem[r_wptr] <= w_emit_report ? w_res_report : w_res_verdict;
        end
        if (w_wr_cnt == 2'd2) begin
            r_mem[r_wptr + PTR_W'(1)] <= w_res_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= r_wptr + PTR_W'(w_wr_cnt);
            r_rptr <= r_rptr + PTR_W'(w_rd);
            r_cnt  <= r_cnt + CNT_W'(w_wr_cnt) - CNT_W'(w_rd);
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = M_TDATA_W'({w_head.verdict, w_head.crc,
                                       w_head.length, w_head.offset});
    assign m_axis_tuser  = w_head.kind;
    assign m_axis_tlast  = w_head.last;

`include "assert_macros.svh"

    `ASSERT_CLK(a_queue_bound, r_cnt <= CNT_W'(FIFO_DEPTH), "result queue overflow")
    `ASSERT_CLK(a_last_phase, w_last_acc |=> (r_phase == PH_SIG), "phase kept at file end")
    `ASSERT_CLK(a_last_offset, w_last_acc |=> (r_off == '0), "offset kept at file end")
    `ASSERT_CLK(a_last_fail, w_last_acc |=> (r_fail == VERDICT_GOOD), "failure kept at file end")
    `ASSERT_CLK(a_fail_sticky, w_hold_fail |=> $stable(r_fail), "failure code changed")
    `ASSERT_CLK(a_idle_holds, !w_acc |=> ($stable(r_off) && $stable(r_phase)), "parser moved")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams PNG-like byte files into the chunk structure checker and compares
// every IDAT report and verdict with a cycle-free model of the chunk walk.
// ----------------------------------------------------------------------------
module testbench;

    import pngck_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // data_byte [7:0]
    logic                  s_axis_tlast;   // last_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // offset, length, crc, verdict, zero fill
    logic                  m_axis_tuser;   // report_kind
    logic                  m_axis_tlast;   // final_of_run

    png_chunk_structure_checker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Idle percentages of the two sides, changed between test phases.
    int send_idle_pct = 11;
    int recv_idle_pct = 83;

    int unsigned cycle_count       = 0;
    int unsigned mismatch_count    = 0;
    int unsigned bytes_sent        = 0;
    int unsigned files_sent        = 0;
    int unsigned results_expected  = 0;
    int unsigned reports_checked   = 0;
    int unsigned verdicts_checked  = 0;

    // Results still owed by the checker, oldest first.
    t_result expected_reports [$];
    t_result head_report;

    // File under construction, in file order.
    logic [7:0] file_bytes [$];

    // ------------------------------------------------------------------
    // Chunk walk model: its own copy of the parser state.
    // ------------------------------------------------------------------
    t_phase                 walk_phase;
    logic [2:0]             walk_count;
    logic [31:0]            walk_word;
    logic [31:0]            walk_len;
    logic [32:0]            walk_skip;
    logic [OFFSET_BITS-1:0] walk_offset;
    logic [OFFSET_BITS-1:0] walk_start;
    logic                   walk_idat_seen;
    logic [2:0]             walk_fail;

    function automatic void restart_png_walk();
        walk_phase     = PH_SIG;
        walk_count     = '0;
        walk_word      = '0;
        walk_len       = '0;
        walk_skip      = '0;
        walk_offset    = '0;
        walk_start     = '0;
        walk_idat_seen = 1'b0;
        walk_fail      = VERDICT_GOOD;
    endfunction

    // Shifts one byte into the big-endian word; true once four bytes are in.
    function automatic bit shift_walk_word(logic [7:0] b);
        walk_word = {walk_word[23:0], b};
        if (walk_count >= 3'd3) begin
            walk_count = '0;
            return 1'b1;
        end
        walk_count = walk_count + 3'd1;
        return 1'b0;
    endfunction

    function automatic logic [2:0] png_verdict_now();
        if (walk_fail != VERDICT_GOOD) return walk_fail;
        if (walk_phase == PH_SIG) return VERDICT_BAD_SIG;
        if (walk_phase == PH_HLEN || walk_phase == PH_HTYPE) return VERDICT_BAD_IHDR;
        if (walk_phase == PH_TAIL && walk_skip == '0)
            return walk_idat_seen ? VERDICT_GOOD : VERDICT_NO_IDAT;
        return VERDICT_BAD_IEND;
    endfunction

    // Advances the model by one accepted byte and queues the results it causes.
    function automatic void walk_png_byte(logic [7:0] b, logic lst);
        t_result rows [2];
        int      n;
        n = 0;
        if (walk_fail == VERDICT_GOOD) begin
            case (walk_phase)
                PH_SIG: begin
                    if (b != SIG_BYTES[walk_count]) begin
                        walk_fail = VERDICT_BAD_SIG;
                    end else if (walk_count >= 3'd7) begin
                        walk_count = '0;
                        walk_phase = PH_HLEN;
                    end else begin
                        walk_count = walk_count + 3'd1;
                    end
                end
                PH_HLEN: begin
                    if (shift_walk_word(b)) begin
                        if (walk_word != IHDR_DATA_LEN) walk_fail = VERDICT_BAD_IHDR;
                        else walk_phase = PH_HTYPE;
                    end
                end
                PH_HTYPE: begin
                    if (shift_walk_word(b)) begin
                        if (walk_word != TYPE_IHDR) begin
                            walk_fail = VERDICT_BAD_IHDR;
                        end else begin
                            walk_phase = PH_HSKIP;
                            walk_skip  = {1'b0, IHDR_DATA_LEN} + 33'd4;
                        end
                    end
                end
                PH_HSKIP, PH_SKIP: begin
                    if (walk_skip != '0) walk_skip = walk_skip - 33'd1;
                    if (walk_skip == '0) walk_phase = PH_CLEN;
                end
                PH_CLEN: begin
                    // The chunk starts at its first length byte.
                    if (walk_count == '0) walk_start = walk_offset;
                    if (shift_walk_word(b)) begin
                        walk_len   = walk_word;
                        walk_phase = PH_CTYPE;
                    end
                end
                PH_CTYPE: begin
                    if (shift_walk_word(b)) begin
                        if (walk_word == TYPE_IDAT) begin
                            walk_idat_seen = 1'b1;
                            walk_skip      = {1'b0, walk_len};
                            walk_phase     = (walk_len == '0) ? PH_ICRC : PH_IDATA;
                        end else if (walk_word == TYPE_IEND) begin
                            if (walk_len != '0) begin
                                walk_fail = VERDICT_BAD_IEND;
                            end else begin
                                walk_skip  = 33'd4;
                                walk_phase = PH_TAIL;
                            end
                        end else begin
                            walk_skip  = {1'b0, walk_len} + 33'd4;
                            walk_phase = PH_SKIP;
                        end
                    end
                end
                PH_IDATA: begin
                    if (walk_skip != '0) walk_skip = walk_skip - 33'd1;
                    if (walk_skip == '0) walk_phase = PH_ICRC;
                end
                PH_ICRC: begin
                    if (shift_walk_word(b)) begin
                        rows[n] = {KIND_IDAT, 32'(walk_start), walk_len, walk_word,
                                   VERDICT_GOOD, 1'b0};
                        n++;
                        walk_phase = PH_CLEN;
                    end
                end
                PH_TAIL: begin
                    // Any byte past the four CRC bytes of IEND is an error.
                    if (walk_skip == '0) walk_fail = VERDICT_BAD_IEND;
                    else walk_skip = walk_skip - 33'd1;
                end
                default: walk_fail = VERDICT_BAD_IEND;
            endcase
        end
        if (walk_offset != '1) walk_offset = walk_offset + OFFSET_BITS'(1);
        if (lst) begin
            rows[n] = {KIND_VERDICT, 32'd0, 32'd0, 32'd0, png_verdict_now(), 1'b0};
            n++;
            restart_png_walk();
        end
        if (n > 0) rows[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) begin
            expected_reports.push_back(rows[i]);
            results_expected++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte sender and file builders.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        walk_png_byte(b, lst);
        bytes_sent++;
    endtask

    // Sends the built file with tlast on its final byte, then clears it.
    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
        files_sent++;
    endtask

    function automatic void put_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void put_signature();
        for (int i = 0; i < 8; i++) file_bytes.push_back(SIG_BYTES[i]);
    endfunction

    function automatic void put_ihdr(logic [31:0] len, logic [31:0] ctype);
        put_word(len);
        put_word(ctype);
        repeat (13) file_bytes.push_back(8'($urandom_range(0, 255)));
        put_word($urandom);
    endfunction

    function automatic void put_chunk(logic [31:0] ctype, int unsigned len,
                                      logic [31:0] crc);
        put_word(len);
        put_word(ctype);
        repeat (len) file_bytes.push_back(8'($urandom_range(0, 255)));
        put_word(crc);
    endfunction

    function automatic void put_iend();
        put_chunk(TYPE_IEND, 0, $urandom);
    endfunction

    // Four random letters, the way ancillary chunk names look.
    function automatic logic [31:0] random_ancillary_type();
        logic [31:0] w;
        for (int i = 0; i < 4; i++)
            w[8*i +: 8] = 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + $urandom_range(0, 25));
        return w;
    endfunction

    function automatic int unsigned random_chunk_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 8);
    endfunction

    // Mostly well-formed files with random content, some damaged, some noise.
    function automatic void build_random_file();
        int unsigned pick;
        int unsigned n;
        int unsigned spot;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            if (pick < 4) put_signature();
            n = $urandom_range(1, 20);
            repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        put_signature();
        put_ihdr(IHDR_DATA_LEN, TYPE_IHDR);
        n = $urandom_range(0, 4);
        repeat (n) begin
            if ($urandom_range(0, 1)) put_chunk(TYPE_IDAT, random_chunk_len(), $urandom);
            else put_chunk(random_ancillary_type(), random_chunk_len(), $urandom);
        end
        if ($urandom_range(0, 11) != 0) put_iend();
        if (pick < 26) begin
            // Flip bits of one byte anywhere in the file.
            spot = $urandom_range(0, file_bytes.size() - 1);
            file_bytes[spot] = file_bytes[spot] ^ 8'($urandom_range(1, 255));
        end else if (pick < 36) begin
            n = $urandom_range(1, file_bytes.size() - 1);
            repeat (n) void'(file_bytes.pop_back());
        end else if (pick < 42) begin
            n = $urandom_range(1, 3);
            repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    task automatic test_signature();
        file_bytes.push_back(SIG_BYTES[0]);           // ends inside the signature
        send_file();
        file_bytes.push_back(SIG_BYTES[0]);           // mismatch, rest ignored
        file_bytes.push_back(SIG_BYTES[1]);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF);
        send_file();
        for (int i = 0; i < 7; i++) file_bytes.push_back(SIG_BYTES[i]);
        file_bytes.push_back(8'h0B);                  // wrong final signature byte
        send_file();
        put_signature();                              // ends inside the IHDR length
        send_file();
    endtask

    task automatic test_ihdr_checks();
        put_signature();
        put_word(32'd14);
        put_word(TYPE_IHDR);
        send_file();
        put_signature();
        put_word(IHDR_DATA_LEN);
        put_word(TYPE_IDAT);
        send_file();
        put_signature();
        put_word(IHDR_DATA_LEN);
        file_bytes.push_back(TYPE_IHDR[31:24]);       // ends inside the IHDR type
        file_bytes.push_back(TYPE_IHDR[23:16]);
        send_file();
    endtask

    task automatic test_iend_rules();
        put_signature();
        put_ihdr(IHDR_DATA_LEN, TYPE_IHDR);
        put_chunk(TYPE_IEND, 1, $urandom);            // IEND with data
        send_file();
        put_signature();
        put_ihdr(IHDR_DATA_LEN, TYPE_IHDR);
        put_chunk(TYPE_IDAT, 0, $urandom);
        put_iend();
        file_bytes.push_back(8'h00);                  // one byte too many
        send_file();
        put_signature();
        put_ihdr(IHDR_DATA_LEN, TYPE_IHDR);
        put_iend();                                   // clean, but no IDAT
        send_file();
        put_signature();
        put_ihdr(IHDR_DATA_LEN, TYPE_IHDR);
        put_chunk(TYPE_IDAT, 2, $urandom);
        put_iend();
        void'(file_bytes.pop_back());                 // tail cut short
        send_file();
    endtask

    task automatic test_idat_reports();
        put_signature();
        put_ihdr(IHDR_DATA_LEN, TYPE_IHDR);
        put_chunk(TYPE_IDAT, 0, 32'hFFFF_FFFF);
        put_chunk(TYPE_IDAT, 3, 32'h0000_0000);
        put_chunk(random_ancillary_type(), 2, $urandom);
        put_iend();
        send_file();
        // The final byte closes the IDAT CRC: report first, verdict second.
        put_signature();
        put_ihdr(IHDR_DATA_LEN, TYPE_IHDR);
        put_chunk(TYPE_IDAT, 1, $urandom);
        send_file();
        // Largest lengths: the skip count needs its carry bit, and the
        // truncated IDAT must not be reported.
        put_signature();
        put_ihdr(IHDR_DATA_LEN, TYPE_IHDR);
        put_word(32'hFFFF_FFFF);
        put_word(random_ancillary_type());
        repeat (5) file_bytes.push_back(8'($urandom_range(0, 255)));
        send_file();
        put_signature();
        put_ihdr(IHDR_DATA_LEN, TYPE_IHDR);
        put_word(32'hFFFF_FFFF);
        put_word(TYPE_IDAT);
        repeat (5) file_bytes.push_back(8'($urandom_range(0, 255)));
        send_file();
    endtask

    task automatic test_random_files(input int send_pct, input int recv_pct);
        int unsigned byte_goal;
        int unsigned result_goal;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        byte_goal     = bytes_sent + 190;
        result_goal   = results_expected + 4;
        while (bytes_sent < byte_goal || results_expected < result_goal) begin
            build_random_file();
            send_file();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls and the field-by-field check.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_reports.size() == 0) begin
                $error("result transfer with nothing expected (kind %0d)", m_axis_tuser);
                mismatch_count++;
            end else begin
                head_report = expected_reports.pop_front();
                compare_field("report_kind", 32'(head_report.kind), 32'(m_axis_tuser));
                compare_field("chunk_offset", head_report.offset, m_axis_tdata[31:0]);
                compare_field("chunk_length", head_report.length, m_axis_tdata[63:32]);
                compare_field("chunk_crc", head_report.crc, m_axis_tdata[95:64]);
                compare_field("verdict", 32'(head_report.verdict), 32'(m_axis_tdata[98:96]));
                compare_field("final_of_run", 32'(head_report.last), 32'(m_axis_tlast));
                compare_field("zero_fill", 32'd0,
                              32'(m_axis_tdata[M_TDATA_W-1:RES_BITS]));
                if (head_report.kind == KIND_IDAT) reports_checked++;
                else verdicts_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_reports.size());
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        restart_png_walk();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_signature();
        test_ihdr_checks();
        test_iend_rules();
        test_idat_reports();
        test_random_files(11, 83);
        test_random_files(83, 11);
        test_random_files(0, 0);

        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d files in %0d byte transfers under three stall mixes.",
                 files_sent, bytes_sent);
        $display("Checked %0d IDAT reports and %0d verdicts, %0d mismatches.",
                 reports_checked, verdicts_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> png_chunk_structure_checker_core.f
+incdir+src
src/pngck_pkg.sv
src/png_chunk_structure_checker_core.sv
bench/testbench.sv
